// ----- rtl/qsu_pkg.sv -----
`timescale 1ns / 1ps
package qsu_pkg;

  // most results one input transaction can cause
  localparam int MAX_RES = 4;
  localparam int CNT_W   = $clog2(MAX_RES + 1);
  localparam int SLOT_W  = $clog2(MAX_RES);

  typedef enum logic [9:0] {
    PH_START = 10'b00_0000_0001,
    PH_BODY  = 10'b00_0000_0010,
    PH_ESC   = 10'b00_0000_0100,
    PH_X1    = 10'b00_0000_1000,
    PH_X2    = 10'b00_0001_0000,
    PH_U0    = 10'b00_0010_0000,
    PH_U1    = 10'b00_0100_0000,
    PH_U2    = 10'b00_1000_0000,
    PH_U3    = 10'b01_0000_0000,
    PH_SKIP  = 10'b10_0000_0000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
  } result_t;

  // all results of one input transaction, slot 0 first
  typedef struct packed {
    logic [CNT_W-1:0]          count;
    result_t [MAX_RES-1:0]     res;
  } bundle_t;

  typedef struct packed {
    logic    valid;
    bundle_t bundle;
  } push_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_A_LO   = 8'h61;
  localparam logic [7:0] CH_F_LO   = 8'h66;
  localparam logic [7:0] BYTE_CR   = 8'h0d;
  localparam logic [7:0] BYTE_LF   = 8'h0a;
  localparam logic [7:0] BYTE_TAB  = 8'h09;

  localparam logic [15:0] UTF8_MAX1 = 16'h007f;
  localparam logic [15:0] UTF8_MAX2 = 16'h07ff;
  localparam logic [7:0]  UTF8_LEAD2 = 8'hc0;
  localparam logic [7:0]  UTF8_LEAD3 = 8'he0;
  localparam logic [7:0]  UTF8_CONT  = 8'h80;
  localparam logic [5:0]  UTF8_MASK  = 6'h3f;

  // {valid, value} of a lower-case hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [7:0] v;
    v = 8'd0;
    if (b >= CH_0 && b <= CH_9) begin
      v = b - CH_0;
      return {1'b1, v[3:0]};
    end else if (b >= CH_A_LO && b <= CH_F_LO) begin
      v = b - CH_A_LO + 8'd10;
      return {1'b1, v[3:0]};
    end
    return 5'd0;
  endfunction

endpackage

// ----- rtl/quoted_string_unescape.sv -----
`timescale 1ns / 1ps
// channel | dir | handshake         | payload
// s_*     | in  | s_tvalid/s_tready | s_tdata[7:0] in_byte, s_tlast token_end
// m_*     | out | m_tvalid/m_tready | m_tdata[7:0] out_byte, m_tuser[1:0] kind,
//         |     |                   | m_tlast run_last
//
// Input side takes one byte per cycle while the bundle queue has room.
// Each input transaction makes 0..4 results; the output side sends one result
// per cycle while m_tready is high, so an input with n results takes n transfers.
// Sustained rate (m_tready high): 1 input per cycle, results avg <= 1 per input.
// rst (synchronous) returns the parser to expecting the opening quote and
// empties the queue and output register; no clearing pass.
// Output stalls fill the queue and then drop s_tready; input gaps only drain it.
module quoted_string_unescape #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  // input stream
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // token_end
  // result stream
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [1:0] m_tuser,   // [1:0] kind: 0 data, 1 done, 2 error
  output logic       m_tlast    // run_last
);
  import qsu_pkg::*;

  push_t   push;
  bundle_t head;
  logic    full;
  logic    head_valid;
  logic    pop;

  // front accepts only when a queue slot is free, whatever the parse state
  assign s_tready = !full;

  // parser: phase tracking, hex gathering, UTF-8 encode; bundles all
  // results of one input transaction
  qsu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .in_last  (s_tlast),
    .push     (push)
  );

  // short bundle queue decouples parsing from result delivery
  qsu_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  // serializer: one result per cycle into the output register while m_tready allows
  qsu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_byte   (m_tdata),
    .out_kind   (m_tuser),
    .out_last   (m_tlast)
  );

  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == KIND_DATA || m_tuser == KIND_DONE || m_tuser == KIND_ERR))
    else $error("bad result kind");
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_DONE || m_tuser == KIND_ERR) |-> m_tdata == 8'd0)
    else $error("status result carries data");
  a_accept_room: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |-> !full)
    else $error("accepted into full queue");

endmodule

// ----- rtl/qsu_front.sv -----
`timescale 1ns / 1ps
module qsu_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  output qsu_pkg::push_t   push
);
  import qsu_pkg::*;

  phase_t      phase, ph_next;
  logic [15:0] acc, acc_next;
  bundle_t     bnd;
  logic [4:0]  hx;
  logic        dig_ok;
  logic [3:0]  dig;
  logic        body_sel;
  logic [15:0] cp;
  logic        accept;

  assign accept = in_valid && in_ready;

  function automatic bundle_t put(input bundle_t bi, input logic [7:0] d, input kind_t k);
    bundle_t bo;
    bo = bi;
    bo.res[bi.count[SLOT_W-1:0]] = '{data: d, kind: k};
    bo.count = bi.count + CNT_W'(1);
    return bo;
  endfunction

  always_comb begin
    hx       = hex_digit(in_byte);
    dig_ok   = hx[4];
    dig      = hx[3:0];
    ph_next  = phase;
    acc_next = acc;
    bnd      = '0;
    body_sel = 1'b0;
    cp       = {acc[11:0], dig};

    case (phase)
      PH_START: begin
        if (in_byte == CH_QUOTE) begin
          ph_next = PH_BODY;
        end else begin
          bnd     = put(bnd, 8'd0, KIND_ERR);
          ph_next = PH_SKIP;
        end
      end
      PH_BODY: begin
        body_sel = 1'b1;
      end
      PH_ESC: begin
        ph_next = PH_BODY;
        case (in_byte)
          CH_R:      bnd = put(bnd, BYTE_CR, KIND_DATA);
          CH_N:      bnd = put(bnd, BYTE_LF, KIND_DATA);
          CH_T:      bnd = put(bnd, BYTE_TAB, KIND_DATA);
          CH_BSLASH: bnd = put(bnd, CH_BSLASH, KIND_DATA);
          CH_QUOTE:  bnd = put(bnd, CH_QUOTE, KIND_DATA);
          CH_X:      ph_next = PH_X1;
          CH_U: begin
            acc_next = 16'd0;
            ph_next  = PH_U0;
          end
          default: begin
            bnd     = put(bnd, 8'd0, KIND_ERR);
            ph_next = PH_SKIP;
          end
        endcase
      end
      PH_X1: begin
        if (!dig_ok) begin
          bnd     = put(bnd, 8'd0, KIND_ERR);
          ph_next = PH_SKIP;
        end else begin
          acc_next = {12'd0, dig};
          ph_next  = PH_X2;
        end
      end
      PH_X2: begin
        ph_next = PH_BODY;
        if (dig_ok) begin
          bnd = put(bnd, {acc[3:0], dig}, KIND_DATA);
        end else begin
          // lone digit flushed, this byte then taken as a string byte
          bnd      = put(bnd, {4'd0, acc[3:0]}, KIND_DATA);
          body_sel = 1'b1;
        end
      end
      PH_U0, PH_U1, PH_U2: begin
        if (!dig_ok) begin
          bnd     = put(bnd, 8'd0, KIND_ERR);
          ph_next = PH_SKIP;
        end else begin
          acc_next = cp;
          ph_next  = (phase == PH_U0) ? PH_U1 : (phase == PH_U1) ? PH_U2 : PH_U3;
        end
      end
      PH_U3: begin
        if (!dig_ok) begin
          bnd     = put(bnd, 8'd0, KIND_ERR);
          ph_next = PH_SKIP;
        end else begin
          acc_next = cp;
          ph_next  = PH_BODY;
          if (cp <= UTF8_MAX1) begin
            bnd = put(bnd, cp[7:0], KIND_DATA);
          end else if (cp <= UTF8_MAX2) begin
            bnd = put(bnd, UTF8_LEAD2 | {3'd0, cp[10:6]}, KIND_DATA);
            bnd = put(bnd, UTF8_CONT | {2'd0, cp[5:0] & UTF8_MASK}, KIND_DATA);
          end else begin
            bnd = put(bnd, UTF8_LEAD3 | {4'd0, cp[15:12]}, KIND_DATA);
            bnd = put(bnd, UTF8_CONT | {2'd0, cp[11:6] & UTF8_MASK}, KIND_DATA);
            bnd = put(bnd, UTF8_CONT | {2'd0, cp[5:0] & UTF8_MASK}, KIND_DATA);
          end
        end
      end
      PH_SKIP: begin
        ph_next = PH_SKIP;
      end
      default: begin
        ph_next = PH_SKIP;
      end
    endcase

    if (body_sel) begin
      if (in_byte == CH_QUOTE) begin
        bnd     = put(bnd, 8'd0, KIND_DONE);
        ph_next = PH_SKIP;
      end else if (in_byte == CH_BSLASH) begin
        ph_next = PH_ESC;
      end else begin
        bnd = put(bnd, in_byte, KIND_DATA);
      end
    end

    // end of token: close out whatever is open
    if (in_last) begin
      if (ph_next == PH_BODY) begin
        bnd = put(bnd, 8'd0, KIND_DONE);
      end else if (ph_next == PH_X2) begin
        bnd = put(bnd, {4'd0, acc_next[3:0]}, KIND_DATA);
        bnd = put(bnd, 8'd0, KIND_DONE);
      end else if (ph_next != PH_SKIP) begin
        bnd = put(bnd, 8'd0, KIND_ERR);
      end
      ph_next  = PH_START;
      acc_next = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      acc   <= 16'd0;
    end else if (accept) begin
      phase <= ph_next;
      acc   <= acc_next;
    end
  end

  assign push.valid  = accept && (bnd.count != '0);
  assign push.bundle = bnd;

  a_mid_token: assert property (@(posedge clk) disable iff (rst)
    accept && !in_last |=> phase != PH_START)
    else $error("front back at start mid token");
  a_token_end: assert property (@(posedge clk) disable iff (rst)
    accept && in_last |=> phase == PH_START && acc == 16'd0)
    else $error("front not reset at token end");
  a_count: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> push.bundle.count <= CNT_W'(MAX_RES))
    else $error("bundle overflow");

endmodule

// ----- rtl/qsu_fifo.sv -----
`timescale 1ns / 1ps
module qsu_fifo #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  qsu_pkg::push_t    push,
  input  logic              pop,
  output logic              full,
  output logic              head_valid,
  output qsu_pkg::bundle_t  head
);
  import qsu_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W2 = $clog2(DEPTH + 1);

  bundle_t             slots [DEPTH];
  logic [PTR_W-1:0]    wr_ptr, rd_ptr;
  logic [CNT_W2-1:0]   fill;
  logic                do_pop;

  assign full       = (fill == CNT_W2'(DEPTH));
  assign head_valid = (fill != '0);
  assign head       = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push.valid, do_pop})
        2'b10:   fill <= fill + CNT_W2'(1);
        2'b01:   fill <= fill - CNT_W2'(1);
        default: fill <= fill;
      endcase
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    full |-> !push.valid)
    else $error("push into full queue");
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W2'(DEPTH))
    else $error("queue fill out of range");
  a_ptr_sync: assert property (@(posedge clk) disable iff (rst)
    (fill == '0) |-> (wr_ptr == rd_ptr))
    else $error("empty queue with split pointers");

endmodule

// ----- rtl/qsu_back.sv -----
`timescale 1ns / 1ps
module qsu_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  qsu_pkg::bundle_t  head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic [1:0]        out_kind,
  output logic              out_last
);
  import qsu_pkg::*;

  logic [SLOT_W-1:0] idx;
  logic              load;
  logic              at_end;
  result_t           cur;

  assign cur    = head.res[idx];
  assign at_end = (CNT_W'(idx) + CNT_W'(1)) == head.count;
  assign load   = head_valid && (!out_valid || out_ready);
  assign pop    = load && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= at_end ? '0 : idx + SLOT_W'(1);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= cur.data;
      out_kind <= cur.kind;
      out_last <= at_end;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> CNT_W'(idx) < head.count)
    else $error("slot index past bundle");
  a_idx_home: assert property (@(posedge clk) disable iff (rst)
    pop |=> idx == '0)
    else $error("slot index not rewound after pop");
  a_nonempty: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> head.count != '0)
    else $error("empty bundle queued");

endmodule
